/* hw/rtl/ktt_pkg.sv */
// Package: table size, widths, result codes and the controller/datapath interface types.
package ktt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_CREATED   = 3'd0,
    ST_REFRESHED = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_MISS      = 3'd3,
    ST_FULL      = 3'd4,
    ST_EXPIRED   = 3'd5,
    ST_IDLE      = 3'd6
  } status_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] deadline;
    logic [15:0] address;
  } entry_t;

  typedef struct packed {
    logic             capture;
    logic             clear_scan;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             apply;
    logic             expire;
    logic             idle_res;
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic out_free;
    logic best_found;
    logic last_due;
  } sts_t;

endpackage

/* hw/rtl/ktt_ctrl.sv */
// Controller: sequences slot scans, updates and expiry emission.
module ktt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ktt_pkg::sts_t sts_i,
  output ktt_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_DECIDE
  } state_e;

  state_e                    state_q, state_d;
  logic [ktt_pkg::IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    cmd_o = '0;
    cmd_o.rd_idx = idx_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.clear_scan = 1'b1;
          idx_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (idx_q == ktt_pkg::IDX_W'(ktt_pkg::TABLE_DEPTH - 1)) begin
          state_d = S_FLUSH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FLUSH: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.out_free) begin
          priority if (!sts_i.op_tick) begin
            cmd_o.apply = 1'b1;
            state_d = S_IDLE;
          end else if (sts_i.best_found) begin
            cmd_o.expire = 1'b1;
            if (sts_i.last_due) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.clear_scan = 1'b1;
              idx_d = '0;
              state_d = S_SCAN;
            end
          end else begin
            cmd_o.idle_res = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
    end
  end

endmodule

/* hw/rtl/ktt_dp.sv */
// Datapath: slot memory, valid bits, clock and count, scan registers and result register.
module ktt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ktt_pkg::cmd_t                 cmd_i,
  output ktt_pkg::sts_t                 sts_o,
  input  logic [ktt_pkg::LIMIT_W-1:0]   limit_i,
  input  logic                          func_i,
  input  logic [31:0]                   key_i,
  input  logic [15:0]                   timeout_i,
  input  logic [15:0]                   address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [31:0]                   key_res_o,
  output logic [15:0]                   address_res_o,
  output logic                          last_o
);

  localparam int unsigned DEPTH = ktt_pkg::TABLE_DEPTH;
  localparam int unsigned IDX_W = ktt_pkg::IDX_W;
  localparam int unsigned CNT_W = ktt_pkg::CNT_W;
  localparam int unsigned CMP_W = ktt_pkg::CMP_W;

  ktt_pkg::entry_t mem_q [DEPTH];
  ktt_pkg::entry_t rd_data_q;

  logic [DEPTH-1:0] valid_q;
  logic [31:0]      now_q;
  logic [CNT_W-1:0] live_q;

  logic        op_func_q;
  logic [31:0] op_key_q;
  logic [15:0] op_timeout_q;
  logic [15:0] op_addr_q;

  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;

  logic             match_found_q, free_found_q, best_found_q;
  logic [CNT_W-1:0] due_cnt_q;
  logic [IDX_W-1:0] match_idx_q, free_idx_q, best_idx_q;
  logic [15:0]      match_addr_q, best_addr_q;
  logic [31:0]      best_age_q, best_key_q;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [31:0] out_key_q;
  logic [15:0] out_addr_q;
  logic        out_last_q;

  logic            slot_live, is_due, is_hit, is_empty;
  logic [31:0]     age;
  logic            ins_ok, rm_op, wr_en, load;
  logic [IDX_W-1:0] wr_idx;
  ktt_pkg::entry_t wr_data;
  ktt_pkg::status_e res_status;
  logic [31:0]     res_key;
  logic [15:0]     res_addr;
  logic            res_last;

  // compare stage
  assign slot_live = valid_q[cmp_idx_q];
  assign age = now_q - rd_data_q.deadline;
  assign is_due = cmp_vld_q && slot_live && !age[31];
  assign is_hit = cmp_vld_q && slot_live && (rd_data_q.key == op_key_q);
  assign is_empty = cmp_vld_q && !slot_live;

  // update decision
  assign rm_op = (op_timeout_q == 16'd0);
  assign ins_ok = !match_found_q && free_found_q && (CMP_W'(live_q) < CMP_W'(limit_i));
  assign wr_en = cmd_i.apply && !rm_op && (match_found_q || ins_ok);
  assign wr_idx = match_found_q ? match_idx_q : free_idx_q;
  assign wr_data = '{key: op_key_q, deadline: now_q + 32'(op_timeout_q), address: op_addr_q};
  assign load = cmd_i.apply || cmd_i.expire || cmd_i.idle_res;

  always_comb begin
    res_status = ktt_pkg::ST_IDLE;
    res_key = '0;
    res_addr = '0;
    res_last = 1'b1;
    priority if (cmd_i.apply) begin
      res_key = op_key_q;
      res_addr = op_addr_q;
      priority if (rm_op && match_found_q) begin
        res_status = ktt_pkg::ST_REMOVED;
        res_addr = match_addr_q;
      end else if (rm_op) begin
        res_status = ktt_pkg::ST_MISS;
      end else if (match_found_q) begin
        res_status = ktt_pkg::ST_REFRESHED;
      end else if (ins_ok) begin
        res_status = ktt_pkg::ST_CREATED;
      end else begin
        res_status = ktt_pkg::ST_FULL;
      end
    end else if (cmd_i.expire) begin
      res_status = ktt_pkg::ST_EXPIRED;
      res_key = best_key_q;
      res_addr = best_addr_q;
      res_last = (due_cnt_q == CNT_W'(1));
    end else begin
      res_status = ktt_pkg::ST_IDLE;
    end
  end

  // slot memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[cmd_i.rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      live_q <= '0;
      now_q <= '0;
      op_func_q <= 1'b0;
      cmp_vld_q <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
      due_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.rd_en;
      if (cmd_i.capture) begin
        op_func_q <= func_i;
        if (func_i) begin
          now_q <= now_q + 32'd1;
        end
      end
      if (cmd_i.apply && rm_op && match_found_q) begin
        valid_q[match_idx_q] <= 1'b0;
        live_q <= live_q - 1'b1;
      end else if (cmd_i.apply && !rm_op && ins_ok) begin
        valid_q[free_idx_q] <= 1'b1;
        live_q <= live_q + 1'b1;
      end else if (cmd_i.expire) begin
        valid_q[best_idx_q] <= 1'b0;
        live_q <= live_q - 1'b1;
      end
      priority if (cmd_i.clear_scan) begin
        match_found_q <= 1'b0;
        free_found_q <= 1'b0;
        best_found_q <= 1'b0;
        due_cnt_q <= '0;
      end else begin
        if (is_hit && !match_found_q) begin
          match_found_q <= 1'b1;
        end
        if (is_empty && !free_found_q) begin
          free_found_q <= 1'b1;
        end
        if (is_due) begin
          best_found_q <= 1'b1;
          due_cnt_q <= due_cnt_q + 1'b1;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_key_q <= key_i;
      op_timeout_q <= timeout_i;
      op_addr_q <= address_i;
    end
    cmp_idx_q <= cmd_i.rd_idx;
    if (is_hit && !match_found_q) begin
      match_idx_q <= cmp_idx_q;
      match_addr_q <= rd_data_q.address;
    end
    if (is_empty && !free_found_q) begin
      free_idx_q <= cmp_idx_q;
    end
    // strictly older wins, so ties keep the lower slot
    if (is_due && (!best_found_q || age > best_age_q)) begin
      best_idx_q <= cmp_idx_q;
      best_age_q <= age;
      best_key_q <= rd_data_q.key;
      best_addr_q <= rd_data_q.address;
    end
    if (load) begin
      out_status_q <= res_status;
      out_key_q <= res_key;
      out_addr_q <= res_addr;
      out_last_q <= res_last;
    end
  end

  assign sts_o.op_tick = op_func_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.best_found = best_found_q;
  assign sts_o.last_due = (due_cnt_q == CNT_W'(1));

  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign key_res_o = out_key_q;
  assign address_res_o = out_addr_q;
  assign last_o = out_last_q;

endmodule

/* hw/rtl/keyed_timeout_table_core.sv */
// Top level: keyed deadline table with quota register, controller and datapath.
//
// Input channel (in_valid_i/in_ready_o) takes one transaction: func_i = 0 updates or
// removes the entry for key_i, func_i = 1 advances the seconds clock by one and expires
// every due entry. Output channel (out_valid_o/out_ready_i) returns one result per update,
// and one result per expired entry (oldest first) or a single idle result per tick; last_o
// marks the final result of a transaction. cfg_valid_i/cfg_ready_o writes the entry quota
// and is always ready; write it only while no transaction is in progress.
// Each pass over the table reads the slot memory one entry per cycle: an update's result is
// offered after the pass, the flush state and the decide state, and the next transaction
// can be taken once the controller is back in its idle state. A tick that expires entries
// runs one pass per expired entry and offers each result after that pass; an idle
// tick times like an update. in_ready_o is high only between transactions. A stalled
// receiver holds the result register; the next pass runs on and then waits until that
// register is taken.
// Reset empties the table at once (valid bits), clears the clock and live count, and sets
// the quota to 16; the slot memory itself is not cleared.
module keyed_timeout_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [31:0] key_i,
  input  logic [15:0] timeout_i,
  input  logic [15:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] key_res_o,
  output logic [15:0] address_res_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_entry_limit_i
);

  ktt_pkg::cmd_t cmd;
  ktt_pkg::sts_t sts;
  logic [ktt_pkg::LIMIT_W-1:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ktt_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_entry_limit_i;
    end
  end

  ktt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ktt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .limit_i       (limit_q),
    .func_i        (func_i),
    .key_i         (key_i),
    .timeout_i     (timeout_i),
    .address_i     (address_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .key_res_o     (key_res_o),
    .address_res_o (address_res_o),
    .last_o        (last_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("transaction accepted while another is in progress");

  a_only_expiry_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (status_o == ktt_pkg::ST_EXPIRED))
    else $error("non-final result that is not an expiry");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.apply || cmd.expire || cmd.idle_res) |-> sts.out_free)
    else $error("result register loaded while occupied");

endmodule

/* tb/keyed_timeout_table_core_tb.sv */
`timescale 1ns / 1ps
// Testbench for keyed_timeout_table_core: directed table, then quota phases of random traffic.
module keyed_timeout_table_core_tb;

  localparam int DEPTH = ktt_pkg::TABLE_DEPTH;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_ITEMS = 58;
  localparam int POOL_SIZE = 16;

  typedef struct packed {
    ktt_pkg::status_e status;
    logic [31:0]      key;
    logic [15:0]      address;
    logic             last;
  } outcome_t;

  typedef struct packed {
    logic             func;
    logic [31:0]      key;
    logic [15:0]      timeout;
    logic [15:0]      address;
    logic             typed;
    ktt_pkg::status_e status;
    logic [31:0]      exp_key;
    logic [15:0]      exp_addr;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        func_in;
  logic [31:0] key_in;
  logic [15:0] timeout_in;
  logic [15:0] address_in;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status_out;
  logic [31:0] key_out;
  logic [15:0] address_out;
  logic        last_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_limit;

  keyed_timeout_table_core u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .func_i            (func_in),
    .key_i             (key_in),
    .timeout_i         (timeout_in),
    .address_i         (address_in),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status_out),
    .key_res_o         (key_out),
    .address_res_o     (address_out),
    .last_o            (last_out),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_entry_limit_i (cfg_limit)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // predicted table state
  logic        tbl_valid    [DEPTH];
  logic [31:0] tbl_key      [DEPTH];
  logic [31:0] tbl_deadline [DEPTH];
  logic [15:0] tbl_addr     [DEPTH];
  logic [31:0] now_s;
  logic [4:0]  live_cnt;
  logic [4:0]  quota;

  outcome_t    step_q[$];
  outcome_t    outcome_q[$];
  stim_row_t   dir_rows[$];
  logic [31:0] key_pool[POOL_SIZE];

  int  err_cnt;
  int  quiet_cycles;
  bit  tx_burst;
  bit  rx_burst;

  function automatic stim_row_t mk_row(logic f, logic [31:0] k, logic [15:0] t,
                                       logic [15:0] a, logic typed, ktt_pkg::status_e st,
                                       logic [31:0] ek, logic [15:0] ea);
    stim_row_t r;
    r.func = f;
    r.key = k;
    r.timeout = t;
    r.address = a;
    r.typed = typed;
    r.status = st;
    r.exp_key = ek;
    r.exp_addr = ea;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void expect_outcome(outcome_t o);
    outcome_q.insert(outcome_q.size(), o);
  endfunction

  function automatic void push_step(ktt_pkg::status_e st, logic [31:0] k, logic [15:0] a,
                                    logic l);
    outcome_t o;
    o.status = st;
    o.key = k;
    o.address = a;
    o.last = l;
    step_q.insert(step_q.size(), o);
  endfunction

  function automatic void predict_table_op(logic f, logic [31:0] k, logic [15:0] t,
                                           logic [15:0] a);
    int          hit;
    int          free_slot;
    int          best;
    logic [31:0] age;
    logic [31:0] best_age;
    step_q.delete();
    if (!f) begin
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i] && tbl_key[i] == k && hit < 0) hit = i;
        if (!tbl_valid[i] && free_slot < 0) free_slot = i;
      end
      if (t == 16'd0) begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          live_cnt = live_cnt - 5'd1;
          push_step(ktt_pkg::ST_REMOVED, k, tbl_addr[hit], 1'b1);
        end else begin
          push_step(ktt_pkg::ST_MISS, k, a, 1'b1);
        end
      end else if (hit >= 0) begin
        tbl_deadline[hit] = now_s + {16'h0, t};
        tbl_addr[hit] = a;
        push_step(ktt_pkg::ST_REFRESHED, k, a, 1'b1);
      end else if (live_cnt >= quota || free_slot < 0) begin
        push_step(ktt_pkg::ST_FULL, k, a, 1'b1);
      end else begin
        tbl_valid[free_slot] = 1'b1;
        tbl_key[free_slot] = k;
        tbl_deadline[free_slot] = now_s + {16'h0, t};
        tbl_addr[free_slot] = a;
        live_cnt = live_cnt + 5'd1;
        push_step(ktt_pkg::ST_CREATED, k, a, 1'b1);
      end
    end else begin
      now_s = now_s + 32'd1;
      do begin
        best = -1;
        best_age = '0;
        for (int i = 0; i < DEPTH; i++) begin
          if (!tbl_valid[i]) continue;
          age = now_s - tbl_deadline[i];
          if (age[31]) continue;
          if (best < 0 || age > best_age) begin
            best = i;
            best_age = age;
          end
        end
        if (best >= 0) begin
          tbl_valid[best] = 1'b0;
          live_cnt = live_cnt - 5'd1;
          push_step(ktt_pkg::ST_EXPIRED, tbl_key[best], tbl_addr[best], 1'b0);
        end
      end while (best >= 0);
      if (step_q.size() == 0) begin
        push_step(ktt_pkg::ST_IDLE, '0, '0, 1'b1);
      end else begin
        step_q[step_q.size() - 1].last = 1'b1;
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  task automatic check_outcome();
    outcome_t e;
    if (outcome_q.size() == 0) begin
      report_mismatch("result with nothing pending, key", key_out, '0);
    end else begin
      e = outcome_q[0];
      outcome_q.delete(0);
      if (status_out !== e.status)
        report_mismatch("status", 32'(status_out), 32'(e.status));
      if (key_out !== e.key) report_mismatch("key_res", key_out, e.key);
      if (address_out !== e.address)
        report_mismatch("address_res", 32'(address_out), 32'(e.address));
      if (last_out !== e.last) report_mismatch("last", 32'(last_out), 32'(e.last));
    end
  endtask

  // caller sits at a falling edge
  task automatic send_item(logic f, logic [31:0] k, logic [15:0] t, logic [15:0] a,
                           logic typed, ktt_pkg::status_e st, logic [31:0] ek,
                           logic [15:0] ea);
    int       gap;
    outcome_t o;
    if ($urandom_range(0, 14) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func_in = f;
    key_in = k;
    timeout_in = t;
    address_in = a;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_table_op(f, k, t, a);
    if (typed) begin
      o.status = st;
      o.key = ek;
      o.address = ea;
      o.last = 1'b1;
      expect_outcome(o);
    end else begin
      foreach (step_q[i]) expect_outcome(step_q[i]);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_quota(logic [4:0] v);
    wait_drained();
    cfg_limit = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    quota = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side
  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_outcome();
      @(negedge clk);
    end
  end

  initial begin
    logic [4:0]  quota_plan[8];
    int          r;
    int          s;
    logic        f;
    logic [31:0] k;
    logic [15:0] t;
    logic [15:0] a;

    rst_n = 1'b0;
    in_valid = 1'b0;
    func_in = 1'b0;
    key_in = '0;
    timeout_in = '0;
    address_in = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_limit = '0;
    err_cnt = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_deadline[i] = '0;
      tbl_addr[i] = '0;
    end
    now_s = '0;
    live_cnt = '0;
    quota = ktt_pkg::LIMIT_RESET;
    quota_plan = '{5'd31, 5'd0, 5'd3, 5'd16, 5'd2, 5'd17, 5'd1, 5'd16};
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // directed: idle tick, misses, extremes, refresh, tie on expiry, lowest free slot
    add_row(mk_row(1'b1, 32'h0, 16'h0, 16'h0, 1'b1, ktt_pkg::ST_IDLE, 32'h0, 16'h0));
    add_row(mk_row(1'b0, 32'h0, 16'h0, 16'h0, 1'b1, ktt_pkg::ST_MISS, 32'h0, 16'h0));
    add_row(mk_row(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, ktt_pkg::ST_CREATED,
                   32'hFFFF_FFFF, 16'hFFFF));
    add_row(mk_row(1'b0, 32'h0, 16'h1, 16'h0, 1'b1, ktt_pkg::ST_CREATED, 32'h0, 16'h0));
    add_row(mk_row(1'b0, 32'h0, 16'h2, 16'h1234, 1'b1, ktt_pkg::ST_REFRESHED,
                   32'h0, 16'h1234));
    add_row(mk_row(1'b0, 32'hA5A5_A5A5, 16'h1, 16'h5A5A, 1'b0, ktt_pkg::ST_CREATED,
                   32'h0, 16'h0));
    add_row(mk_row(1'b0, 32'h5A5A_5A5A, 16'h1, 16'hA5A5, 1'b0, ktt_pkg::ST_CREATED,
                   32'h0, 16'h0));
    add_row(mk_row(1'b0, 32'h8000_0000, 16'h3, 16'h8000, 1'b0, ktt_pkg::ST_CREATED,
                   32'h0, 16'h0));
    add_row(mk_row(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, ktt_pkg::ST_CREATED,
                   32'h0, 16'h0));
    add_row(mk_row(1'b1, 32'h0, 16'h0, 16'h0, 1'b0, ktt_pkg::ST_CREATED, 32'h0, 16'h0));
    add_row(mk_row(1'b0, 32'h7FFF_FFFF, 16'h0, 16'h0001, 1'b1, ktt_pkg::ST_MISS,
                   32'h7FFF_FFFF, 16'h0001));
    add_row(mk_row(1'b0, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b1, ktt_pkg::ST_REMOVED,
                   32'hFFFF_FFFF, 16'hFFFF));
    add_row(mk_row(1'b0, 32'h1357_9BDF, 16'h1, 16'h0F0F, 1'b0, ktt_pkg::ST_CREATED,
                   32'h0, 16'h0));
    add_row(mk_row(1'b0, 32'h2468_ACE0, 16'h8000, 16'hF0F0, 1'b0, ktt_pkg::ST_CREATED,
                   32'h0, 16'h0));
    add_row(mk_row(1'b1, 32'h0, 16'h0, 16'h0, 1'b0, ktt_pkg::ST_CREATED, 32'h0, 16'h0));
    add_row(mk_row(1'b1, 32'h0, 16'h0, 16'h0, 1'b1, ktt_pkg::ST_IDLE, 32'h0, 16'h0));
    add_row(mk_row(1'b0, 32'h2468_ACE0, 16'h0, 16'h7777, 1'b0, ktt_pkg::ST_CREATED,
                   32'h0, 16'h0));

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].func, dir_rows[i].key, dir_rows[i].timeout, dir_rows[i].address,
                dir_rows[i].typed, dir_rows[i].status, dir_rows[i].exp_key,
                dir_rows[i].exp_addr);

    foreach (quota_plan[p]) begin
      write_quota(quota_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 59) == 0) wait_drained();
        if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
        r = $urandom_range(0, 99);
        a = 16'($urandom);
        if (r < 35) begin
          f = 1'b1;
          k = $urandom;
          t = 16'($urandom);
        end else begin
          f = 1'b0;
          k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
          s = $urandom_range(0, 9);
          if (r < 50) t = 16'h0;
          else if (s < 7) t = 16'($urandom_range(1, 12));
          else if (s < 9) t = 16'($urandom);
          else t = 16'hFFFF;
        end
        send_item(f, k, t, a, 1'b0, ktt_pkg::ST_CREATED, '0, '0);
      end
    end

    in_valid = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (DEPTH + 4) @(negedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ktt_pkg.sv
hw/rtl/ktt_ctrl.sv
hw/rtl/ktt_dp.sv
hw/rtl/keyed_timeout_table_core.sv
tb/keyed_timeout_table_core_tb.sv
